/* hw/rtl/osmp_pkg.sv */
// Package for the ordered store with max-priority lookup.
// Holds default sizes, operation and error codes, and the cell control struct.
// No dependencies.
`default_nettype none

package osmp_pkg;

    localparam int DEPTH_DEF          = 16;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int PRIORITY_WIDTH_DEF = 8;

    localparam int MODE_WIDTH  = 2;
    localparam int ERROR_WIDTH = 2;

    localparam logic [MODE_WIDTH-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_PEEK = 2'd2;

    localparam logic [ERROR_WIDTH-1:0] ERR_OK    = 2'd0;
    localparam logic [ERROR_WIDTH-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERROR_WIDTH-1:0] ERR_FULL  = 2'd2;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;    // write the pushed entry into this cell
        logic shift;   // take the entry of the next cell (pop)
        logic in_use;  // this cell lies below the stored count
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/osmp_in_if.sv */
// Input channel of the ordered store: valid/ready handshake with one operation item.
// Depends on osmp_pkg for the mode width.
`default_nettype none

interface osmp_in_if #(
    parameter int DATA_WIDTH     = osmp_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = osmp_pkg::PRIORITY_WIDTH_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic [osmp_pkg::MODE_WIDTH-1:0] mode;
    logic [DATA_WIDTH-1:0]           item_value;
    logic [PRIORITY_WIDTH-1:0]       item_priority;

    modport source (output valid, mode, item_value, item_priority, input ready);
    modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

`default_nettype wire

/* hw/rtl/osmp_out_if.sv */
// Result channel of the ordered store: valid/ready handshake with one status item.
// Depends on osmp_pkg for the error code width.
`default_nettype none

interface osmp_out_if #(
    parameter int DATA_WIDTH     = osmp_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = osmp_pkg::PRIORITY_WIDTH_DEF,
    parameter int COUNT_WIDTH    = $clog2(osmp_pkg::DEPTH_DEF + 1)
) ();
    logic                             valid;
    logic                             ready;
    logic [COUNT_WIDTH-1:0]           entry_count;
    logic                             is_empty;
    logic [DATA_WIDTH-1:0]            front_value;
    logic [PRIORITY_WIDTH-1:0]        front_priority;
    logic [DATA_WIDTH-1:0]            back_value;
    logic [PRIORITY_WIDTH-1:0]        back_priority;
    logic [DATA_WIDTH-1:0]            top_value;
    logic [PRIORITY_WIDTH-1:0]        top_priority;
    logic [osmp_pkg::ERROR_WIDTH-1:0] error_code;

    modport source (output valid, entry_count, is_empty, front_value, front_priority,
                    back_value, back_priority, top_value, top_priority, error_code,
                    input ready);
    modport sink   (input valid, entry_count, is_empty, front_value, front_priority,
                    back_value, back_priority, top_value, top_priority, error_code,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/osmp_cell.sv */
// One storage cell of the ordered store chain: holds an entry and the running
// top and back entries handed on from the previous cell. Depends on osmp_pkg.
`default_nettype none

module osmp_cell #(
    parameter int DATA_WIDTH     = osmp_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = osmp_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire osmp_pkg::cell_ctrl_t       ctrl,
    input  wire logic [DATA_WIDTH-1:0]      push_value,
    input  wire logic [PRIORITY_WIDTH-1:0]  push_priority,
    input  wire logic [DATA_WIDTH-1:0]      next_value,
    input  wire logic [PRIORITY_WIDTH-1:0]  next_priority,
    input  wire logic [DATA_WIDTH-1:0]      prev_top_value,
    input  wire logic [PRIORITY_WIDTH-1:0]  prev_top_priority,
    input  wire logic [DATA_WIDTH-1:0]      prev_back_value,
    input  wire logic [PRIORITY_WIDTH-1:0]  prev_back_priority,
    output logic      [DATA_WIDTH-1:0]      entry_value,
    output logic      [PRIORITY_WIDTH-1:0]  entry_priority,
    output logic      [DATA_WIDTH-1:0]      top_value,
    output logic      [PRIORITY_WIDTH-1:0]  top_priority,
    output logic      [DATA_WIDTH-1:0]      back_value,
    output logic      [PRIORITY_WIDTH-1:0]  back_priority
);

    logic [DATA_WIDTH-1:0]     value_reg, value_next;
    logic [PRIORITY_WIDTH-1:0] priority_reg, priority_next;
    logic [DATA_WIDTH-1:0]     top_value_reg, top_value_next;
    logic [PRIORITY_WIDTH-1:0] top_priority_reg, top_priority_next;
    logic [DATA_WIDTH-1:0]     back_value_reg, back_value_next;
    logic [PRIORITY_WIDTH-1:0] back_priority_reg, back_priority_next;

    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        if (ctrl.load)
        begin
            value_next    = push_value;
            priority_next = push_priority;
        end
        else if (ctrl.shift)
        begin
            value_next    = next_value;
            priority_next = next_priority;
        end
    end

    // A used cell takes over the running top on a greater or equal priority,
    // so that ties go to the newer entry further along the chain.
    always_comb
    begin
        top_value_next     = prev_top_value;
        top_priority_next  = prev_top_priority;
        back_value_next    = prev_back_value;
        back_priority_next = prev_back_priority;
        if (ctrl.in_use)
        begin
            back_value_next    = value_reg;
            back_priority_next = priority_reg;
            if (priority_reg >= prev_top_priority)
            begin
                top_value_next    = value_reg;
                top_priority_next = priority_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg         <= value_next;
        priority_reg      <= priority_next;
        top_value_reg     <= top_value_next;
        top_priority_reg  <= top_priority_next;
        back_value_reg    <= back_value_next;
        back_priority_reg <= back_priority_next;
    end

    assign entry_value    = value_reg;
    assign entry_priority = priority_reg;
    assign top_value      = top_value_reg;
    assign top_priority   = top_priority_reg;
    assign back_value     = back_value_reg;
    assign back_priority  = back_priority_reg;

endmodule

`default_nettype wire

/* hw/rtl/ordered_store_with_max_priority_core.sv */
// Top level of the ordered store with max-priority lookup.
// Depends on osmp_pkg, osmp_in_if, osmp_out_if and osmp_cell.
//
// The block keeps up to DEPTH (value, priority) entries in arrival order in a
// chain of DEPTH cells. A push appends at the back, a pop drops the oldest entry
// and a peek changes nothing; every item yields one result with the count, the
// front, back and top entries and an error code. The top entry is found by a
// running maximum that moves one cell along the chain per clock, and a new item
// is taken only once the previous result has entered the output register.
`default_nettype none

module ordered_store_with_max_priority_core #(
    parameter int DEPTH          = osmp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH     = osmp_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = osmp_pkg::PRIORITY_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    osmp_in_if.sink   in_ch,
    osmp_out_if.source out_ch
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                           state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    scan_cnt_reg, scan_cnt_next;
    logic [osmp_pkg::ERROR_WIDTH-1:0] err_reg, err_next;

    logic                             out_valid_reg, out_valid_next;
    logic [CW-1:0]                    o_count_reg;
    logic                             o_empty_reg;
    logic [DATA_WIDTH-1:0]            o_front_value_reg;
    logic [PRIORITY_WIDTH-1:0]        o_front_priority_reg;
    logic [DATA_WIDTH-1:0]            o_back_value_reg;
    logic [PRIORITY_WIDTH-1:0]        o_back_priority_reg;
    logic [DATA_WIDTH-1:0]            o_top_value_reg;
    logic [PRIORITY_WIDTH-1:0]        o_top_priority_reg;
    logic [osmp_pkg::ERROR_WIDTH-1:0] o_err_reg;

    logic in_fire;
    logic do_push;
    logic do_pop;
    logic scan_done;

    logic [DATA_WIDTH-1:0]     entry_value_w    [DEPTH];
    logic [PRIORITY_WIDTH-1:0] entry_priority_w [DEPTH];
    logic [DATA_WIDTH-1:0]     top_value_w      [DEPTH];
    logic [PRIORITY_WIDTH-1:0] top_priority_w   [DEPTH];
    logic [DATA_WIDTH-1:0]     back_value_w     [DEPTH];
    logic [PRIORITY_WIDTH-1:0] back_priority_w  [DEPTH];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign do_push     = in_fire && (in_ch.mode == osmp_pkg::MODE_PUSH)
                         && (count_reg != CW'(DEPTH));
    assign do_pop      = in_fire && (in_ch.mode == osmp_pkg::MODE_POP)
                         && (count_reg != '0);
    assign scan_done   = (state_reg == ST_SCAN) && (scan_cnt_reg == '0)
                         && (!out_valid_reg || out_ch.ready);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            osmp_pkg::cell_ctrl_t      ctrl;
            logic [DATA_WIDTH-1:0]     nxt_value;
            logic [PRIORITY_WIDTH-1:0] nxt_priority;
            logic [DATA_WIDTH-1:0]     prv_top_value;
            logic [PRIORITY_WIDTH-1:0] prv_top_priority;
            logic [DATA_WIDTH-1:0]     prv_back_value;
            logic [PRIORITY_WIDTH-1:0] prv_back_priority;

            assign ctrl.load   = do_push && (count_reg == CW'(gi));
            assign ctrl.shift  = do_pop;
            assign ctrl.in_use = (CW'(gi) < count_reg);

            if (gi == DEPTH - 1)
            begin : g_last
                assign nxt_value    = '0;
                assign nxt_priority = '0;
            end
            else
            begin : g_mid
                assign nxt_value    = entry_value_w[gi + 1];
                assign nxt_priority = entry_priority_w[gi + 1];
            end

            if (gi == 0)
            begin : g_first
                assign prv_top_value     = '0;
                assign prv_top_priority  = '0;
                assign prv_back_value    = '0;
                assign prv_back_priority = '0;
            end
            else
            begin : g_rest
                assign prv_top_value     = top_value_w[gi - 1];
                assign prv_top_priority  = top_priority_w[gi - 1];
                assign prv_back_value    = back_value_w[gi - 1];
                assign prv_back_priority = back_priority_w[gi - 1];
            end

            osmp_cell #(
                .DATA_WIDTH     (DATA_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk                (clk),
                .ctrl               (ctrl),
                .push_value         (in_ch.item_value),
                .push_priority      (in_ch.item_priority),
                .next_value         (nxt_value),
                .next_priority      (nxt_priority),
                .prev_top_value     (prv_top_value),
                .prev_top_priority  (prv_top_priority),
                .prev_back_value    (prv_back_value),
                .prev_back_priority (prv_back_priority),
                .entry_value        (entry_value_w[gi]),
                .entry_priority     (entry_priority_w[gi]),
                .top_value          (top_value_w[gi]),
                .top_priority       (top_priority_w[gi]),
                .back_value         (back_value_w[gi]),
                .back_priority      (back_priority_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = CW'(DEPTH);
                    err_next      = osmp_pkg::ERR_OK;
                    if (do_push)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (do_pop)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else if (in_ch.mode == osmp_pkg::MODE_PUSH)
                    begin
                        err_next = osmp_pkg::ERR_FULL;
                    end
                    else if (in_ch.mode == osmp_pkg::MODE_POP)
                    begin
                        err_next = osmp_pkg::ERR_EMPTY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg != '0)
                begin
                    scan_cnt_next = scan_cnt_reg - CW'(1);
                end
                else if (scan_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            err_reg       <= osmp_pkg::ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The last cell of the chain holds the settled top and back entries.
    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            o_count_reg         <= count_reg;
            o_empty_reg         <= (count_reg == '0);
            o_front_value_reg   <= (count_reg == '0) ? '0 : entry_value_w[0];
            o_front_priority_reg <= (count_reg == '0) ? '0 : entry_priority_w[0];
            o_back_value_reg    <= back_value_w[DEPTH-1];
            o_back_priority_reg <= back_priority_w[DEPTH-1];
            o_top_value_reg     <= top_value_w[DEPTH-1];
            o_top_priority_reg  <= top_priority_w[DEPTH-1];
            o_err_reg           <= err_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.entry_count    = o_count_reg;
    assign out_ch.is_empty       = o_empty_reg;
    assign out_ch.front_value    = o_front_value_reg;
    assign out_ch.front_priority = o_front_priority_reg;
    assign out_ch.back_value     = o_back_value_reg;
    assign out_ch.back_priority  = o_back_priority_reg;
    assign out_ch.top_value      = o_top_value_reg;
    assign out_ch.top_priority   = o_top_priority_reg;
    assign out_ch.error_code     = o_err_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stored count exceeds the depth");

    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SCAN))
        else $error("result offered without a completed scan");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the store");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !do_push && !do_pop) |=> $stable(count_reg))
        else $error("count changed on a peek or a rejected operation");

    a_no_take_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !in_ch.ready)
        else $error("input taken while a scan is running");
`endif

endmodule

`default_nettype wire
